// File: design/r4bf_pkg.sv
`default_nettype none
package r4bf_pkg;

    localparam int BF_IDX_W  = 8;
    localparam int OUT_IDX_W = 10;
    localparam int TADDR_W   = 10;
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_BFLY = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PITCH  = 2'd0,
        CFG_GROUP  = 2'd1,
        CFG_STRIDE = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [CFG_W-1:0] pitch_log2;
        logic [CFG_W-1:0] group_len_log2;
        logic [CFG_W-1:0] stride_log2;
    } t_cfg;

endpackage
`default_nettype wire

// File: design/r4bf_front.sv
`default_nettype none
module r4bf_front #(
    parameter int CB = 24,
    parameter int AW = 10
) (
    input  r4bf_pkg::t_cfg                        i_cfg,
    input  logic                                  i_req_type,
    input  logic [r4bf_pkg::BF_IDX_W-1:0]         i_butterfly_index,
    input  logic [r4bf_pkg::TADDR_W-1:0]          i_table_addr,
    input  logic [2*CB-1:0]                       i_sample_b,
    input  logic [2*CB-1:0]                       i_table_word,
    output logic                                  o_is_load,
    output logic [r4bf_pkg::OUT_IDX_W-1:0]        o_base,
    output logic [AW-1:0]                         o_addr_b,
    output logic [AW-1:0]                         o_addr_c,
    output logic [AW-1:0]                         o_addr_d,
    output logic [2*CB-1:0]                       o_word_b
);
    localparam int IW  = r4bf_pkg::BF_IDX_W;
    localparam int OW  = r4bf_pkg::OUT_IDX_W;
    localparam int SKW = IW + (1 << r4bf_pkg::CFG_W) + 1;
    localparam int TW  = (AW > r4bf_pkg::TADDR_W) ? AW : r4bf_pkg::TADDR_W;

    logic [IW-1:0]  k;
    logic [IW-1:0]  grp;
    logic [OW-1:0]  grp_ofs;
    logic [SKW-1:0] sk1;
    logic [SKW-1:0] sk2;
    logic [SKW-1:0] sk3;
    logic [TW-1:0]  taddr_ext;

    always_comb begin
        k         = i_butterfly_index & ~({IW{1'b1}} << i_cfg.pitch_log2);
        grp       = i_butterfly_index >> i_cfg.pitch_log2;
        grp_ofs   = OW'(grp) << i_cfg.group_len_log2;
        sk1       = SKW'(k) << i_cfg.stride_log2;
        sk2       = sk1 << 1;
        sk3       = sk2 + sk1;
        taddr_ext = TW'(i_table_addr);
        o_is_load = (i_req_type == r4bf_pkg::REQ_LOAD);
        o_base    = grp_ofs + OW'(k);
        // a load item reuses the first twiddle address and the b slot
        o_addr_b  = o_is_load ? taddr_ext[AW-1:0] : sk1[AW-1:0];
        o_addr_c  = sk2[AW-1:0];
        o_addr_d  = sk3[AW-1:0];
        o_word_b  = o_is_load ? i_table_word : i_sample_b;
    end

endmodule
`default_nettype wire

// File: design/r4bf_queue.sv
`default_nettype none
module r4bf_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);
    logic [W-1:0] r_slot [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_data;
        end
    end

endmodule
`default_nettype wire

// File: design/r4bf_back.sv
`default_nettype none
module r4bf_back #(
    parameter int TD = 1024,
    parameter int CB = 24
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  r4bf_pkg::t_cfg                     i_cfg,
    input  logic                               i_q_empty,
    output logic                               o_q_pop,
    input  logic                               i_is_load,
    input  logic [r4bf_pkg::OUT_IDX_W-1:0]     i_base,
    input  logic [$clog2(TD)-1:0]              i_addr_b,
    input  logic [$clog2(TD)-1:0]              i_addr_c,
    input  logic [$clog2(TD)-1:0]              i_addr_d,
    input  logic [2*CB-1:0]                    i_sa,
    input  logic [2*CB-1:0]                    i_sb,
    input  logic [2*CB-1:0]                    i_sc,
    input  logic [2*CB-1:0]                    i_sd,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [r4bf_pkg::OUT_IDX_W-1:0]     o_out_index,
    output logic [2*CB-1:0]                    o_out_value,
    output logic                               o_saturated,
    output logic                               o_last
);
    localparam int AW   = $clog2(TD);
    localparam int OW   = r4bf_pkg::OUT_IDX_W;
    localparam int SW   = 2 * CB;
    localparam int FB   = CB - 2;
    localparam int PW   = 2 * CB;
    localparam int SUMW = 2 * CB + 2;
    localparam int RW   = SUMW - FB;
    localparam int BW   = RW + 2;
    localparam logic signed [SUMW-1:0] RND = SUMW'(1) << (FB - 1);
    localparam logic signed [BW-1:0]   HI  = (BW'(1) << (CB - 1)) - BW'(1);
    localparam logic signed [BW-1:0]   LO  = ~HI;

    typedef enum logic [3:0] {
        PH_B   = 4'b0001,
        PH_C   = 4'b0010,
        PH_D   = 4'b0100,
        PH_GAP = 4'b1000
    } t_phase;

    function automatic logic [CB:0] f_clip(input logic signed [BW-1:0] v);
        logic [CB:0] r;
        if (v > HI) begin
            r = {1'b1, HI[CB-1:0]};
        end else if (v < LO) begin
            r = {1'b1, LO[CB-1:0]};
        end else begin
            r = {1'b0, v[CB-1:0]};
        end
        return r;
    endfunction

    logic [SW-1:0] r_mem [TD];

    // issue stage
    logic          r_busy;
    t_phase        r_ph;
    logic [OW-1:0] r_cbase;
    logic [AW-1:0] r_ta, r_tc, r_td;
    logic [SW-1:0] r_sa, r_sb, r_sc, r_sd;
    logic [AW-1:0] rd_addr;
    logic [SW-1:0] rd_sample;

    // table read stage
    logic          r_rv;
    t_phase        r_rtag;
    logic [SW-1:0] r_tw;
    logic [SW-1:0] r_rs;

    // product stage
    logic                 r_pv;
    t_phase               r_ptag;
    logic signed [PW-1:0] r_prr, r_pii, r_pri, r_pir;

    // twiddled samples of one butterfly
    logic                 r_fv;
    logic signed [RW-1:0] r_bre, r_bim, r_cre, r_cim, r_dre, r_dim;
    logic [SW-1:0]        r_fa;
    logic [OW-1:0]        r_fbase;

    // result bank
    logic          r_ev;
    logic [1:0]    r_em;
    logic [OW-1:0] r_oidx [4];
    logic [SW-1:0] r_oval [4];
    logic          r_osat [4];

    logic en;
    logic drain;

    logic signed [CB-1:0]   sr, si, wr, wi;
    logic signed [SUMW-1:0] sum_re, sum_im;
    logic signed [SUMW-1:0] rnd_re, rnd_im;
    logic signed [RW-1:0]   tw_re, tw_im;

    logic signed [BW-1:0] ar, ai, br, bi, cr, ci, dr, di;
    logic signed [BW-1:0] t0r, t0i, t1r, t1i, u0r, u0i, u1r, u1i;
    logic signed [BW-1:0] vr [4];
    logic signed [BW-1:0] vi [4];
    logic [CB:0]          cl_re [4];
    logic [CB:0]          cl_im [4];
    logic [OW-1:0]        pitch;
    logic [OW-1:0]        idx [4];

    assign drain   = r_fv && (!r_ev || (i_ready && (r_em == 2'd3)));
    assign en      = !r_fv || drain;
    assign o_q_pop = en && !i_q_empty && (!r_busy || (r_ph == PH_GAP));

    // ---- issue sequencer: one table read per phase, then a gap phase with no read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ph   <= PH_B;
        end else if (en) begin
            if (o_q_pop) begin
                r_busy <= !i_is_load;
                r_ph   <= PH_B;
            end else if (r_busy) begin
                case (r_ph)
                    PH_B:    r_ph <= PH_C;
                    PH_C:    r_ph <= PH_D;
                    PH_D:    r_ph <= PH_GAP;
                    PH_GAP:  r_busy <= 1'b0;
                    default: r_busy <= 1'b0;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && !i_is_load) begin
            r_cbase <= i_base;
            r_ta    <= i_addr_b;
            r_tc    <= i_addr_c;
            r_td    <= i_addr_d;
            r_sa    <= i_sa;
            r_sb    <= i_sb;
            r_sc    <= i_sc;
            r_sd    <= i_sd;
        end
    end

    always_comb begin
        case (r_ph)
            PH_B: begin
                rd_addr   = r_ta;
                rd_sample = r_sb;
            end
            PH_C: begin
                rd_addr   = r_tc;
                rd_sample = r_sc;
            end
            default: begin
                rd_addr   = r_td;
                rd_sample = r_sd;
            end
        endcase
    end

    // ---- twiddle table
    always_ff @(posedge i_clk) begin
        if (o_q_pop && i_is_load) begin
            r_mem[i_addr_b] <= i_sb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tw <= r_mem[rd_addr];
            r_rs <= rd_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv <= 1'b0;
            r_pv <= 1'b0;
        end else if (en) begin
            r_rv <= r_busy && (r_ph != PH_GAP);
            r_pv <= r_rv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rtag <= r_ph;
            r_ptag <= r_rtag;
        end
    end

    // ---- complex multiply
    assign sr = r_rs[SW-1:CB];
    assign si = r_rs[CB-1:0];
    assign wr = r_tw[SW-1:CB];
    assign wi = r_tw[CB-1:0];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prr <= sr * wr;
            r_pii <= si * wi;
            r_pri <= sr * wi;
            r_pir <= si * wr;
        end
    end

    // ---- round half up of the product pair
    always_comb begin
        sum_re = SUMW'(r_prr) - SUMW'(r_pii);
        sum_im = SUMW'(r_pri) + SUMW'(r_pir);
        rnd_re = sum_re + RND;
        rnd_im = sum_im + RND;
        tw_re  = RW'(rnd_re >>> FB);
        tw_im  = RW'(rnd_im >>> FB);
    end

    always_ff @(posedge i_clk) begin
        if (en && r_pv) begin
            case (r_ptag)
                PH_B: begin
                    r_bre <= tw_re;
                    r_bim <= tw_im;
                end
                PH_C: begin
                    r_cre <= tw_re;
                    r_cim <= tw_im;
                end
                PH_D: begin
                    r_dre <= tw_re;
                    r_dim <= tw_im;
                end
                default: ;
            endcase
        end
        if (en && r_busy && (r_ph == PH_D)) begin
            r_fa    <= r_sa;
            r_fbase <= r_cbase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else begin
            r_fv <= (en && r_pv && (r_ptag == PH_D)) || (r_fv && !drain);
        end
    end

    // ---- butterfly and saturation
    always_comb begin
        ar  = BW'($signed(r_fa[SW-1:CB]));
        ai  = BW'($signed(r_fa[CB-1:0]));
        br  = BW'(r_bre);
        bi  = BW'(r_bim);
        cr  = BW'(r_cre);
        ci  = BW'(r_cim);
        dr  = BW'(r_dre);
        di  = BW'(r_dim);
        t0r = ar + cr;
        t0i = ai + ci;
        t1r = ar - cr;
        t1i = ai - ci;
        u0r = br + dr;
        u0i = bi + di;
        u1r = br - dr;
        u1i = bi - di;
        vr[0] = t0r + u0r;
        vi[0] = t0i + u0i;
        vr[1] = t1r - u1i;
        vi[1] = t1i + u1r;
        vr[2] = t0r - u0r;
        vi[2] = t0i - u0i;
        vr[3] = t1r + u1i;
        vi[3] = t1i - u1r;
        pitch  = OW'(1) << i_cfg.pitch_log2;
        idx[0] = r_fbase;
        idx[1] = r_fbase + pitch;
        idx[2] = r_fbase + (pitch << 1);
        idx[3] = r_fbase + pitch + (pitch << 1);
        for (int m = 0; m < 4; m++) begin
            cl_re[m] = f_clip(vr[m]);
            cl_im[m] = f_clip(vi[m]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (drain) begin
            for (int m = 0; m < 4; m++) begin
                r_oidx[m] <= idx[m];
                r_oval[m] <= {cl_re[m][CB-1:0], cl_im[m][CB-1:0]};
                r_osat[m] <= cl_re[m][CB] | cl_im[m][CB];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev <= 1'b0;
            r_em <= 2'd0;
        end else if (drain) begin
            r_ev <= 1'b1;
            r_em <= 2'd0;
        end else if (r_ev && i_ready) begin
            if (r_em == 2'd3) begin
                r_ev <= 1'b0;
            end
            r_em <= r_em + 2'd1;
        end
    end

    assign o_valid     = r_ev;
    assign o_out_index = r_oidx[r_em];
    assign o_out_value = r_oval[r_em];
    assign o_saturated = r_osat[r_em];
    assign o_last      = r_ev && (r_em == 2'd3);

endmodule
`default_nettype wire

// File: design/radix4_twiddled_butterfly_stage.sv
// radix-4 fft butterfly stage with twiddle table. load items (req_type 0) write one
// twiddle word and produce nothing; butterfly items produce four results in order
// m = 0..3, the fourth flagged by o_last. a butterfly holds the back end for its
// three twiddle reads on the table's single read port plus one spare slot, matched
// to the four results on the one result channel; the next item is popped no earlier
// than that spare slot. results pass the issue, table read, product, twiddled-sample
// and result bank registers. a 2-entry queue separates input acceptance from the
// back end. loads and butterflies are kept in order, so a load affects only
// butterflies accepted after it. the user must write configuration only while the
// block is idle, which the block does not enforce; o_cfg_ready is always high.
`default_nettype none
module radix4_twiddled_butterfly_stage #(
    parameter int TABLE_DEPTH    = 1024,
    parameter int COMPONENT_BITS = 24
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic                                 i_req_type,
    input  logic [r4bf_pkg::BF_IDX_W-1:0]        i_butterfly_index,
    input  logic [2*COMPONENT_BITS-1:0]          i_sample_a,
    input  logic [2*COMPONENT_BITS-1:0]          i_sample_b,
    input  logic [2*COMPONENT_BITS-1:0]          i_sample_c,
    input  logic [2*COMPONENT_BITS-1:0]          i_sample_d,
    input  logic [r4bf_pkg::TADDR_W-1:0]         i_table_addr,
    input  logic [2*COMPONENT_BITS-1:0]          i_table_word,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [r4bf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [r4bf_pkg::CFG_W-1:0]           i_cfg_data,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [r4bf_pkg::OUT_IDX_W-1:0]       o_out_index,
    output logic [2*COMPONENT_BITS-1:0]          o_out_value,
    output logic                                 o_saturated,
    output logic                                 o_last
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int SW = 2 * COMPONENT_BITS;
    localparam int OW = r4bf_pkg::OUT_IDX_W;
    localparam int QW = 1 + OW + 3 * AW + 4 * SW;

    r4bf_pkg::t_cfg r_cfg;

    logic          f_is_load;
    logic [OW-1:0] f_base;
    logic [AW-1:0] f_ab, f_ac, f_ad;
    logic [SW-1:0] f_wb;

    logic          q_push, q_pop, q_full, q_empty;
    logic [QW-1:0] q_wdata, q_rdata;

    logic          q_is_load;
    logic [OW-1:0] q_base;
    logic [AW-1:0] q_ab, q_ac, q_ad;
    logic [SW-1:0] q_sa, q_sb, q_sc, q_sd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pitch_log2     <= 4'd0;
            r_cfg.group_len_log2 <= 4'd2;
            r_cfg.stride_log2    <= 4'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                r4bf_pkg::CFG_PITCH:  r_cfg.pitch_log2     <= i_cfg_data;
                r4bf_pkg::CFG_GROUP:  r_cfg.group_len_log2 <= i_cfg_data;
                r4bf_pkg::CFG_STRIDE: r_cfg.stride_log2    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    r4bf_front #(
        .CB (COMPONENT_BITS),
        .AW (AW)
    ) u_front (
        .i_cfg             (r_cfg),
        .i_req_type        (i_req_type),
        .i_butterfly_index (i_butterfly_index),
        .i_table_addr      (i_table_addr),
        .i_sample_b        (i_sample_b),
        .i_table_word      (i_table_word),
        .o_is_load         (f_is_load),
        .o_base            (f_base),
        .o_addr_b          (f_ab),
        .o_addr_c          (f_ac),
        .o_addr_d          (f_ad),
        .o_word_b          (f_wb)
    );

    assign o_ready = !q_full;
    assign q_push  = i_valid && !q_full;
    assign q_wdata = {f_is_load, f_base, f_ab, f_ac, f_ad,
                      i_sample_a, f_wb, i_sample_c, i_sample_d};

    r4bf_queue #(
        .W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    assign {q_is_load, q_base, q_ab, q_ac, q_ad, q_sa, q_sb, q_sc, q_sd} = q_rdata;

    r4bf_back #(
        .TD (TABLE_DEPTH),
        .CB (COMPONENT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_empty   (q_empty),
        .o_q_pop     (q_pop),
        .i_is_load   (q_is_load),
        .i_base      (q_base),
        .i_addr_b    (q_ab),
        .i_addr_c    (q_ac),
        .i_addr_d    (q_ad),
        .i_sa        (q_sa),
        .i_sb        (q_sb),
        .i_sc        (q_sc),
        .i_sd        (q_sd),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_index (o_out_index),
        .o_out_value (o_out_value),
        .o_saturated (o_saturated),
        .o_last      (o_last)
    );

`ifndef SYNTH
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("back end popped an empty queue");

    a_burst_starts_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> !o_last)
        else $error("result burst did not start at the first result");

    a_last_then_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last) |=> !o_last)
        else $error("fourth result not followed by a new burst");
`endif

endmodule
`default_nettype wire

// File: dv/radix4_twiddled_butterfly_stage_test.sv
`default_nettype none
module radix4_twiddled_butterfly_stage_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  DEPTH      = 1024;
    localparam int  CYCLE_CAP  = 400000;
    localparam logic [r4bf_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam longint COMP_MAX = 64'sd8388607;
    localparam longint COMP_MIN = -64'sd8388608;

    typedef struct {
        logic [r4bf_pkg::OUT_IDX_W-1:0] index;
        logic [47:0]          value;
        logic                 sat;
        logic                 last;
    } t_bfly_out;

    class bfly_scoreboard;
        logic [47:0]      twiddles [DEPTH];
        r4bf_pkg::t_cfg   cfg;
        t_bfly_out     pending_q [$];
        int            errors;
        int            matched;
        int            sat_seen;

        function new();
            cfg.pitch_log2     = 4'd0;
            cfg.group_len_log2 = 4'd2;
            cfg.stride_log2    = 4'd0;
            errors   = 0;
            matched  = 0;
            sat_seen = 0;
        endfunction

        function void write_reg(logic [r4bf_pkg::CFG_IDX_W-1:0] idx,
                                logic [r4bf_pkg::CFG_W-1:0] data);
            case (idx)
                r4bf_pkg::CFG_PITCH:  cfg.pitch_log2     = data;
                r4bf_pkg::CFG_GROUP:  cfg.group_len_log2 = data;
                r4bf_pkg::CFG_STRIDE: cfg.stride_log2    = data;
                default: ;
            endcase
        endfunction

        function void rotate(logic [47:0] smp, int addr, output longint re, output longint im);
            longint sr, si, wr, wi;
            logic [47:0] w;
            w  = twiddles[addr & (DEPTH - 1)];
            sr = $signed(smp[47:24]);
            si = $signed(smp[23:0]);
            wr = $signed(w[47:24]);
            wi = $signed(w[23:0]);
            // round half up of the pair sum, kept wide
            re = (sr * wr - si * wi + 64'sd2097152) >>> 22;
            im = (sr * wi + si * wr + 64'sd2097152) >>> 22;
        endfunction

        function logic [23:0] clip(longint v, inout logic flag);
            if (v > COMP_MAX) begin
                v = COMP_MAX;
                flag = 1'b1;
            end
            if (v < COMP_MIN) begin
                v = COMP_MIN;
                flag = 1'b1;
            end
            return v[23:0];
        endfunction

        function void note_item(logic req, logic [7:0] bidx, logic [47:0] a, logic [47:0] b,
                                logic [47:0] c, logic [47:0] d, logic [9:0] taddr,
                                logic [47:0] tword);
            int unsigned pitch, k, s, base;
            longint ar, ai, br, bi, cr, ci, dr, di;
            longint rr [4];
            longint ri [4];
            t_bfly_out o;
            if (req == r4bf_pkg::REQ_LOAD) begin
                twiddles[taddr] = tword;
                return;
            end
            pitch = 1 << cfg.pitch_log2;
            k     = bidx & (pitch - 1);
            s     = 1 << cfg.stride_log2;
            base  = ((bidx >> cfg.pitch_log2) << cfg.group_len_log2) + k;
            ar = $signed(a[47:24]);
            ai = $signed(a[23:0]);
            rotate(b, s * k, br, bi);
            rotate(c, s * k * 2, cr, ci);
            rotate(d, s * k * 3, dr, di);
            rr[0] = (ar + cr) + (br + dr);  ri[0] = (ai + ci) + (bi + di);
            rr[1] = (ar - cr) - (bi - di);  ri[1] = (ai - ci) + (br - dr);
            rr[2] = (ar + cr) - (br + dr);  ri[2] = (ai + ci) - (bi + di);
            rr[3] = (ar - cr) + (bi - di);  ri[3] = (ai - ci) - (br - dr);
            for (int m = 0; m < 4; m++) begin
                o.sat   = 1'b0;
                o.value[47:24] = clip(rr[m], o.sat);
                o.value[23:0]  = clip(ri[m], o.sat);
                o.index = r4bf_pkg::OUT_IDX_W'((base + m * pitch) & 10'h3FF);
                o.last  = (m == 3);
                pending_q.push_back(o);
            end
        endfunction

        function void check_result(logic [9:0] idx, logic [47:0] val, logic sat, logic last);
            t_bfly_out e;
            if (pending_q.size() == 0) begin
                $display("%0t unexpected result: index %0d value %h sat %b last %b",
                         $time, idx, val, sat, last);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (sat) sat_seen++;
            if (idx !== e.index) begin
                $display("%0t out_index: expected %0d actual %0d", $time, e.index, idx);
                errors++;
            end
            if (val !== e.value) begin
                $display("%0t out_value: expected %h actual %h", $time, e.value, val);
                errors++;
            end
            if (sat !== e.sat) begin
                $display("%0t saturated: expected %b actual %b", $time, e.sat, sat);
                errors++;
            end
            if (last !== e.last) begin
                $display("%0t last: expected %b actual %b", $time, e.last, last);
                errors++;
            end
            matched++;
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_req_type = r4bf_pkg::REQ_LOAD;
    logic [7:0]  i_butterfly_index = '0;
    logic [47:0] i_sample_a = '0;
    logic [47:0] i_sample_b = '0;
    logic [47:0] i_sample_c = '0;
    logic [47:0] i_sample_d = '0;
    logic [9:0]  i_table_addr = '0;
    logic [47:0] i_table_word = '0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [r4bf_pkg::CFG_IDX_W-1:0] i_cfg_index = r4bf_pkg::CFG_PITCH;
    logic [r4bf_pkg::CFG_W-1:0]     i_cfg_data = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [9:0]  o_out_index;
    logic [47:0] o_out_value;
    logic        o_saturated;
    logic        o_last;

    radix4_twiddled_butterfly_stage dut (.*);

    bfly_scoreboard sb = new();
    int  cycles = 0;
    int  burst_left = 0;
    int  bfly_sent = 0;
    int  hold_request = 0;

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("radix4_twiddled_butterfly_stage_test: FAIL");
            $finish;
        end
    end

    // input and result monitors
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready)
            sb.note_item(i_req_type, i_butterfly_index, i_sample_a, i_sample_b, i_sample_c,
                         i_sample_d, i_table_addr, i_table_word);
        if (i_rst_n && o_valid && i_ready)
            sb.check_result(o_out_index, o_out_value, o_saturated, o_last);
    end

    // receiver: stretches of always-ready, coin flips and mostly-stalled
    initial begin
        int mode, stretch, hold;
        mode = 0;
        stretch = 0;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request != 0) begin
                hold = hold_request;
                hold_request = 0;
            end
            if (stretch == 0) begin
                mode = $urandom_range(2, 0);
                stretch = $urandom_range(40, 5);
            end
            stretch--;
            if (hold > 0) begin
                hold--;
                i_ready <= 1'b0;
            end else begin
                case (mode)
                    0: i_ready <= 1'b1;
                    1: i_ready <= 1'($urandom_range(1, 0));
                    default: i_ready <= ($urandom_range(3, 0) == 0);
                endcase
            end
        end
    end

    function automatic logic [23:0] pick_comp();
        case ($urandom_range(5, 0))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'h000000;
            3: return 24'hFFFFFF;
            default: return 24'($urandom());
        endcase
    endfunction

    function automatic logic [47:0] pick_sample();
        if ($urandom_range(1, 0)) return 48'({$urandom(), $urandom()});
        return {pick_comp(), pick_comp()};
    endfunction

    task automatic send(logic req, logic [7:0] bidx, logic [47:0] a, logic [47:0] b,
                        logic [47:0] c, logic [47:0] d, logic [9:0] taddr, logic [47:0] tword);
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(8, 1)) @(negedge i_clk);
            burst_left = $urandom_range(12, 1);
        end
        burst_left--;
        i_valid <= 1'b1;
        i_req_type <= req;
        i_butterfly_index <= bidx;
        i_sample_a <= a;
        i_sample_b <= b;
        i_sample_c <= c;
        i_sample_d <= d;
        i_table_addr <= taddr;
        i_table_word <= tword;
        if (req == r4bf_pkg::REQ_BFLY) bfly_sent++;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    task automatic send_random();
        if ($urandom_range(5, 0) == 0)
            send(r4bf_pkg::REQ_LOAD, 8'($urandom()), pick_sample(), pick_sample(),
                 pick_sample(), pick_sample(), 10'($urandom()), pick_sample());
        else
            send(r4bf_pkg::REQ_BFLY, 8'($urandom()), pick_sample(), pick_sample(),
                 pick_sample(), pick_sample(), 10'($urandom()), pick_sample());
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending_q.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [r4bf_pkg::CFG_IDX_W-1:0] idx,
                             logic [r4bf_pkg::CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_cfg(logic [3:0] p, logic [3:0] g, logic [3:0] s);
        write_reg(r4bf_pkg::CFG_PITCH, p);
        write_reg(r4bf_pkg::CFG_GROUP, g);
        write_reg(r4bf_pkg::CFG_STRIDE, s);
    endtask

    initial begin
        logic [3:0] phase_cfg [6][3];
        phase_cfg = '{'{4'd0, 4'd0, 4'd0}, '{4'd2, 4'd4, 4'd1}, '{4'd8, 4'd10, 4'd10},
                      '{4'd15, 4'd15, 4'd15}, '{4'd3, 4'd5, 4'd2}, '{4'd1, 4'd3, 4'd7}};
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // fill every entry that a butterfly can reach under the settings used here
        for (int n = 0; n < 88; n += 2)
            send(r4bf_pkg::REQ_LOAD, 8'($urandom()), '0, '0, '0, '0, 10'(n), pick_sample());
        for (int n = 128; n < 512; n += 128)
            send(r4bf_pkg::REQ_LOAD, 8'($urandom()), '0, '0, '0, '0, 10'(n), pick_sample());
        // unity twiddle at entry zero, then extremes under the reset settings
        send(r4bf_pkg::REQ_LOAD, 8'd0, '0, '0, '0, '0, 10'd0, {24'h400000, 24'h000000});
        send(r4bf_pkg::REQ_BFLY, 8'd0, '0, '0, '0, '0, 10'h3FF, '1);
        send(r4bf_pkg::REQ_BFLY, 8'd0, {2{24'h7FFFFF}}, {2{24'h7FFFFF}}, {2{24'h7FFFFF}},
             {2{24'h7FFFFF}}, '0, '0);
        send(r4bf_pkg::REQ_BFLY, 8'd255, {2{24'h800000}}, {2{24'h800000}}, {2{24'h800000}},
             {2{24'h800000}}, '0, '0);
        send(r4bf_pkg::REQ_BFLY, 8'd255, {24'h7FFFFF, 24'h800000}, {24'h800000, 24'h7FFFFF},
             {24'h7FFFFF, 24'h800000}, {24'h800000, 24'h7FFFFF}, '0, '0);
        send(r4bf_pkg::REQ_LOAD, 8'hFF, '1, '1, '1, '1, 10'h3FF, {24'h800000, 24'h7FFFFF});
        send(r4bf_pkg::REQ_LOAD, 8'hAA, '1, '1, '1, '1, 10'h3FF, {24'h7FFFFF, 24'h800000});
        for (int n = 0; n < 6; n++) send_random();
        drain();

        // register index past the list is ignored
        write_reg(CFG_SPARE, 4'hF);
        for (int ph = 0; ph < 6; ph++) begin
            set_cfg(phase_cfg[ph][0], phase_cfg[ph][1], phase_cfg[ph][2]);
            if (ph == 2) hold_request = 300;
            for (int n = 0; n < 8; n++) send_random();
            drain();
        end

        $display("covered %0d butterflies, %0d results matched, %0d saturated, 7 settings",
                 bfly_sent, sb.matched, sb.sat_seen);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("radix4_twiddled_butterfly_stage_test: PASS");
        else
            $display("radix4_twiddled_butterfly_stage_test: FAIL");
        $finish;
    end
endmodule
`default_nettype wire
